### hdl/crms_pkg.sv
// shared types, constants and codes for the clipped rms block with fault log
package crms_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_BATCH   = 65536;
    localparam int STAMP_W     = 32;
    localparam int TALLY_W     = 17;
    localparam int FAULT_W     = 20;
    localparam int SUM_W       = 48;
    localparam int LIMIT_W     = 15;
    localparam int PHASE_W     = 2;
    localparam int SQ_W        = 2 * SAMPLE_BITS;
    localparam int DIV_STEPS   = SUM_W;
    localparam int ROOT_STEPS  = SUM_W / 2;
    localparam int ROOT_W      = SUM_W / 2;
    localparam int CNT_W       = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = LIMIT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_SELECT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LIMIT   = 1'd1;

    localparam logic [PHASE_W-1:0] PHASE_A = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_B = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_C = 2'd2;

    localparam logic KIND_FAULT = 1'b0;
    localparam logic KIND_RMS   = 1'b1;

    localparam logic [PHASE_W-1:0] PHASE_RESET = PHASE_A;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'h7FFF;

    typedef struct packed {
        logic [STAMP_W-1:0]            stamp;
        logic signed [SAMPLE_BITS-1:0] volt_a;
        logic signed [SAMPLE_BITS-1:0] volt_b;
        logic signed [SAMPLE_BITS-1:0] volt_c;
        logic                          final_sample;
    } in_item_t;

    typedef struct packed {
        logic                          kind;
        logic [STAMP_W-1:0]            out_stamp;
        logic signed [SAMPLE_BITS-1:0] out_value;
        logic [PHASE_W-1:0]            phase_code;
        logic [FAULT_W-1:0]            fault_index;
        logic [TALLY_W-1:0]            good_count;
        logic                          empty_batch;
        logic                          last_of_run;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic div_step;
        logic root_step;
        logic load_rms;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic item_final;
        logic batch_empty;
        logic out_free;
    } dp_stat_t;

endpackage

### hdl/crms_ctrl.sv
// controller: accepts samples, sequences the batch divide and square root
module crms_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  crms_pkg::dp_stat_t  stat,
    output crms_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_ROOT,
        ST_EMIT
    } state_t;

    state_t                     state_reg, state_next;
    logic [crms_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = stat.out_free;
                cmd.take = in_valid && stat.out_free;
                if (cmd.take && stat.item_final)
                begin
                    state_next = ST_DIVIDE;
                    cnt_next   = '0;
                end
            end
            ST_DIVIDE:
            begin
                if (stat.batch_empty)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    if (cnt_reg == crms_pkg::CNT_W'(crms_pkg::DIV_STEPS - 1))
                    begin
                        state_next = ST_ROOT;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (cnt_reg == crms_pkg::CNT_W'(crms_pkg::ROOT_STEPS - 1))
                begin
                    state_next = ST_EMIT;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                cmd.load_rms = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // the rms result never overwrites a record that is still waiting
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_rms |-> stat.out_free)
        else $error("rms loaded while output register busy");

    // a final sample closes the input until its rms result is out
    a_final_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take && stat.item_final |=> !in_ready)
        else $error("input open right after a final sample");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < crms_pkg::CNT_W'(crms_pkg::DIV_STEPS))
        else $error("step counter out of range");

endmodule

### hdl/crms_dpath.sv
// datapath: phase select, clip test, accumulation, divider, square root, output register
module crms_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_en,
    input  logic [crms_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [crms_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  crms_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output crms_pkg::out_item_t                 out_data,
    input  crms_pkg::ctrl_cmd_t                 cmd,
    output crms_pkg::dp_stat_t                  stat
);

    localparam int SB = crms_pkg::SAMPLE_BITS;
    localparam int SW = crms_pkg::SUM_W;
    localparam int TW = crms_pkg::TALLY_W;
    localparam int FW = crms_pkg::FAULT_W;
    localparam int RW = crms_pkg::ROOT_W;

    logic [crms_pkg::PHASE_W-1:0] phase_sel_reg;
    logic [crms_pkg::LIMIT_W-1:0] clip_limit_reg;
    logic [SW-1:0]                sum_reg, sum_next;
    logic [TW-1:0]                tally_reg, tally_next;
    logic [FW-1:0]                fault_total_reg, fault_total_next;
    logic [SW-1:0]                work_reg, work_next;
    logic [TW-1:0]                divisor_reg, divisor_next;
    logic [TW-1:0]                div_rem_reg, div_rem_next;
    logic [RW-1:0]                root_reg, root_next;
    logic [RW+1:0]                root_rem_reg, root_rem_next;
    logic                         empty_reg, empty_next;
    logic [crms_pkg::PHASE_W-1:0] rms_phase_reg, rms_phase_next;
    logic                         out_valid_reg, out_valid_next;
    crms_pkg::out_item_t          out_data_reg, out_data_next;

    logic [crms_pkg::PHASE_W-1:0] phase;
    logic signed [SB-1:0]         volt;
    logic [SB-1:0]                mag;
    logic                         clipped;
    logic [crms_pkg::SQ_W-1:0]    square;
    logic [SW:0]                  sum_add;
    logic [SW-1:0]                sum_upd;
    logic [TW-1:0]                tally_upd;
    logic [TW:0]                  div_trial;
    logic [TW:0]                  div_diff;
    logic [RW+3:0]                root_trial;
    logic [RW+3:0]                root_cur;
    logic [RW+3:0]                root_diff;
    logic                         out_free;

    always_comb
    begin
        case (phase_sel_reg)
            crms_pkg::PHASE_A:
            begin
                phase = crms_pkg::PHASE_A;
                volt  = in_data.volt_a;
            end
            crms_pkg::PHASE_B:
            begin
                phase = crms_pkg::PHASE_B;
                volt  = in_data.volt_b;
            end
            default:
            begin
                // the unused code falls back to phase c
                phase = crms_pkg::PHASE_C;
                volt  = in_data.volt_c;
            end
        endcase
    end

    assign mag     = volt[SB-1] ? (~volt + 1'b1) : volt;
    assign clipped = mag > SB'(clip_limit_reg);
    assign square  = mag * mag;
    assign sum_add = {1'b0, sum_reg} + (SW+1)'(square);

    always_comb
    begin
        sum_upd   = sum_reg;
        tally_upd = tally_reg;
        if (!clipped && (tally_reg < TW'(crms_pkg::MAX_BATCH)))
        begin
            sum_upd   = sum_add[SW] ? {SW{1'b1}} : sum_add[SW-1:0];
            tally_upd = tally_reg + 1'b1;
        end
    end

    // restoring divide, one quotient bit per step
    assign div_trial = {div_rem_reg, work_reg[SW-1]};
    assign div_diff  = div_trial - {1'b0, divisor_reg};

    // digit-by-digit root, two radicand bits per step
    assign root_cur   = {root_rem_reg, work_reg[SW-1:SW-2]};
    assign root_trial = {2'b00, root_reg, 2'b01};
    assign root_diff  = root_cur - root_trial;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        sum_next         = sum_reg;
        tally_next       = tally_reg;
        fault_total_next = fault_total_reg;
        work_next        = work_reg;
        divisor_next     = divisor_reg;
        div_rem_next     = div_rem_reg;
        root_next        = root_reg;
        root_rem_next    = root_rem_reg;
        empty_next       = empty_reg;
        rms_phase_next   = rms_phase_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_data_next    = out_data_reg;

        if (cmd.take)
        begin
            if (clipped)
            begin
                out_valid_next            = 1'b1;
                out_data_next.kind        = crms_pkg::KIND_FAULT;
                out_data_next.out_stamp   = in_data.stamp;
                out_data_next.out_value   = volt;
                out_data_next.phase_code  = phase;
                out_data_next.fault_index = fault_total_reg;
                out_data_next.good_count  = '0;
                out_data_next.empty_batch = 1'b0;
                out_data_next.last_of_run = !in_data.final_sample;
                if (fault_total_reg != {FW{1'b1}})
                begin
                    fault_total_next = fault_total_reg + 1'b1;
                end
            end
            if (in_data.final_sample)
            begin
                work_next      = sum_upd;
                divisor_next   = tally_upd;
                empty_next     = (tally_upd == '0);
                rms_phase_next = phase;
                div_rem_next   = '0;
                root_next      = '0;
                root_rem_next  = '0;
                sum_next       = '0;
                tally_next     = '0;
            end
            else
            begin
                sum_next   = sum_upd;
                tally_next = tally_upd;
            end
        end

        if (cmd.div_step)
        begin
            if (!div_diff[TW])
            begin
                div_rem_next = div_diff[TW-1:0];
                work_next    = {work_reg[SW-2:0], 1'b1};
            end
            else
            begin
                div_rem_next = div_trial[TW-1:0];
                work_next    = {work_reg[SW-2:0], 1'b0};
            end
        end

        if (cmd.root_step)
        begin
            work_next = {work_reg[SW-3:0], 2'b00};
            if (!root_diff[RW+3])
            begin
                root_rem_next = root_diff[RW+1:0];
                root_next     = {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                root_rem_next = root_cur[RW+1:0];
                root_next     = {root_reg[RW-2:0], 1'b0};
            end
        end

        if (cmd.load_rms)
        begin
            out_valid_next            = 1'b1;
            out_data_next.kind        = crms_pkg::KIND_RMS;
            out_data_next.out_stamp   = '0;
            out_data_next.out_value   = empty_reg ? '0 : root_reg[SB-1:0];
            out_data_next.phase_code  = rms_phase_reg;
            out_data_next.fault_index = '0;
            out_data_next.good_count  = divisor_reg;
            out_data_next.empty_batch = empty_reg;
            out_data_next.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_sel_reg   <= crms_pkg::PHASE_RESET;
            clip_limit_reg  <= crms_pkg::LIMIT_RESET;
            sum_reg         <= '0;
            tally_reg       <= '0;
            fault_total_reg <= '0;
            divisor_reg     <= '0;
            div_rem_reg     <= '0;
            empty_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_en)
            begin
                unique case (cfg_addr)
                    crms_pkg::CFG_PHASE_SELECT:
                        phase_sel_reg <= cfg_data[crms_pkg::PHASE_W-1:0];
                    crms_pkg::CFG_CLIP_LIMIT:
                        clip_limit_reg <= cfg_data[crms_pkg::LIMIT_W-1:0];
                    default:
                        clip_limit_reg <= clip_limit_reg;
                endcase
            end
            sum_reg         <= sum_next;
            tally_reg       <= tally_next;
            fault_total_reg <= fault_total_next;
            divisor_reg     <= divisor_next;
            div_rem_reg     <= div_rem_next;
            empty_reg       <= empty_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg      <= work_next;
        root_reg      <= root_next;
        root_rem_reg  <= root_rem_next;
        rms_phase_reg <= rms_phase_next;
        out_data_reg  <= out_data_next;
    end

    assign out_valid        = out_valid_reg;
    assign out_data         = out_data_reg;
    assign stat.item_final  = in_data.final_sample;
    assign stat.batch_empty = empty_reg;
    assign stat.out_free    = out_free;

    // fault index only counts up, across batches
    a_fault_mono: assert property (@(posedge clk) disable iff (!rst_n)
        fault_total_reg >= $past(fault_total_reg))
        else $error("fault index went backwards");

    // a result waiting on a stalled output is not dropped
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_data_reg))
        else $error("stalled result lost or changed");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        div_rem_reg == '0 || div_rem_reg < divisor_reg)
        else $error("divider remainder not below divisor");

endmodule

### hdl/clipped_rms_with_fault_log.sv
// top level: clipped rms of one selected phase with fault record output
// non-final sample: one per cycle if output free; fault record valid the cycle after transfer
// final sample: rms result after 48 divide steps and 24 root steps, counted by the shared
//   step counter; no steps for an empty batch; input held meanwhile
// a clipped final sample gives its fault record first, then the rms result
// rst_n is asynchronous, active low: clears batch sums, fault index and output valid
module clipped_rms_with_fault_log (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  crms_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output crms_pkg::out_item_t                 out_data,
    input  logic                                cfg_en,
    input  logic [crms_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [crms_pkg::CFG_DATA_W-1:0]     cfg_data
);

    crms_pkg::ctrl_cmd_t cmd;
    crms_pkg::dp_stat_t  stat;

    crms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    crms_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_en    (cfg_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
